>>> rtl/modinv_pkg.sv
// Package for the modular inverse block: width default, state codes and the
// command and status structs passed between controller and datapath.
// No dependencies.
package modinv_pkg;

   // Default operand width.
   localparam int MODINV_WIDTH = 31;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic r1_zero;
      logic div_last;
   } status_type;

endpackage

>>> rtl/modinv_dpath.sv
// Datapath of the modular inverse block: remainder and coefficient registers,
// a restoring divider that also forms quotient times coefficient, and the
// final reduction. Depends on modinv_pkg.
module modinv_dpath import modinv_pkg::*; #(
   parameter int WIDTH = MODINV_WIDTH
) (
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [WIDTH-1:0] req_value_a,
   input  logic [WIDTH-1:0] req_modulus,
   output status_type       status,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic [WIDTH-1:0] rsp_common_divisor
);

   // Coefficients are signed and bounded by the modulus; two extra bits keep
   // the partial product sums of the divider exact.
   localparam int SW = WIDTH + 2;
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [SW-1:0]    s0_ff, s0_in;
   logic [SW-1:0]    s1_ff, s1_in;
   logic [SW-1:0]    acc_ff, acc_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic [WIDTH-1:0] gcd_ff, gcd_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH+1:0] diff;
   logic             qbit;
   logic [SW-1:0]    s0_neg;
   logic [WIDTH-1:0] s0_mag;
   logic [WIDTH-1:0] s0_pos;

   // One restoring division step, with the quotient bit also folded into
   // the running product of quotient and coefficient.
   assign trial = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff  = {1'b0, trial} - {2'b00, r1_ff};
   assign qbit  = ~diff[WIDTH+1];

   // Magnitude views of the final coefficient for the reduction.
   assign s0_neg = '0 - s0_ff;
   assign s0_mag = s0_neg[WIDTH-1:0];
   assign s0_pos = s0_ff[WIDTH-1:0];

   always_comb begin
      m_in   = m_ff;
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      inv_in = inv_ff;
      gcd_in = gcd_ff;

      // Take a new request.
      if (cmd.load) begin
         m_in  = req_modulus;
         r0_in = req_value_a;
         r1_in = req_modulus;
         s0_in = SW'(1);
         s1_in = '0;
      end

      // Prepare a division of r0 by r1.
      if (cmd.div_init) begin
         rem_in = '0;
         dvd_in = r0_ff;
         acc_in = '0;
         cnt_in = CW'(WIDTH);
      end

      // One quotient bit per cycle.
      if (cmd.div_step) begin
         rem_in = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         acc_in = {acc_ff[SW-2:0], 1'b0} + (qbit ? s1_ff : '0);
         cnt_in = cnt_ff - CW'(1);
      end

      // Advance one Euclid round.
      if (cmd.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff - acc_ff;
      end

      // Reduce the coefficient into 1..m, a zero remainder giving m; a zero modulus gives 0.
      if (cmd.finish) begin
         gcd_in = r0_ff;
         if (m_ff == '0) begin
            inv_in = '0;
         end else if (s0_ff[SW-1]) begin
            inv_in = (s0_mag == m_ff) ? m_ff : m_ff - s0_mag;
         end else begin
            inv_in = (s0_pos == '0 || s0_pos == m_ff) ? m_ff : s0_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      inv_ff <= inv_in;
      gcd_ff <= gcd_in;
   end

   assign status.r1_zero  = (r1_ff == '0);
   assign status.div_last = (cnt_ff == CW'(1));

   assign rsp_inverse        = inv_ff;
   assign rsp_common_divisor = gcd_ff;

endmodule

>>> rtl/modinv_ctrl.sv
// Controller of the modular inverse block: sequences Euclid rounds and
// divider steps and raises the result strobe. Depends on modinv_pkg.
module modinv_ctrl import modinv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // State and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.r1_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

>>> rtl/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block: controller plus datapath.
// Depends on modinv_pkg, modinv_ctrl and modinv_dpath.
//
// A request (req_value_a, req_modulus) is taken when start is high and busy
// is low. The block runs the extended Euclidean algorithm and reports the
// coefficient of a reduced into 1..modulus on rsp_inverse, with gcd(a, m) on
// rsp_common_divisor; the inverse is meaningful only when the gcd is 1. A zero
// modulus gives inverse 0 and gcd a. The result is held for exactly one cycle
// with rsp_valid high and cannot be stalled. Each Euclid round passes the
// check state, the steps of the bit-serial restoring divider (one quotient
// bit a cycle) and the update state; a request takes up to about 46 rounds
// for 31-bit operands. busy is low again in the strobe cycle, so the next
// request may be taken while the result is shown.
module modular_inverse_ext_euclid import modinv_pkg::*; #(
   parameter int WIDTH = MODINV_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_value_a,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic [WIDTH-1:0] rsp_common_divisor
);

   cmd_type    cmd;
   status_type status;

   modinv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   modinv_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .req_value_a        (req_value_a),
      .req_modulus        (req_modulus),
      .status             (status),
      .rsp_inverse        (rsp_inverse),
      .rsp_common_divisor (rsp_common_divisor)
   );

endmodule

>>> rtl/modinv_checker.sv
// Port-level checks for the modular inverse block, bound to the top level.
// Depends on modinv_pkg and modular_inverse_ext_euclid.
module modinv_checker import modinv_pkg::*; #(
   parameter int WIDTH = MODINV_WIDTH
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [WIDTH-1:0] rsp_inverse,
   input logic [WIDTH-1:0] rsp_common_divisor
);

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   // The result strobe is a single cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // The block is ready again while the result is shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy high during result strobe");

   // Work ends only with a result.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy fell without a result");

   // A shown result carries fully known values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_inverse, rsp_common_divisor}))
      else $error("unknown bits in a shown result");

endmodule

bind modular_inverse_ext_euclid modinv_checker #(
   .WIDTH (WIDTH)
) u_modinv_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_inverse        (rsp_inverse),
   .rsp_common_divisor (rsp_common_divisor)
);

>>> test/modinv_result_checker.sv
// Result checker for the modular inverse block: predicts each result from the
// accepted request and compares it with the strobed response.
// Depends on nothing but its ports; the testbench top instantiates it.
module modinv_result_checker #(
   parameter int WIDTH = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [WIDTH-1:0] req_value_a,
   input  logic [WIDTH-1:0] req_modulus,
   input  logic             rsp_valid,
   input  logic [WIDTH-1:0] rsp_inverse,
   input  logic [WIDTH-1:0] rsp_common_divisor,
   output int               mismatch_count,
   output int               pending_requests
);

   typedef struct packed {
      logic [WIDTH-1:0] inverse;
      logic [WIDTH-1:0] common_divisor;
   } inverse_result_type;

   // Predicted results, oldest request first.
   inverse_result_type predicted_inverses[$];

   // Extended Euclid on 64-bit words; the coefficient of a wraps as two's
   // complement and is folded into 1..m at the end.
   function automatic inverse_result_type euclid_inverse(input logic [WIDTH-1:0] a,
                                                         input logic [WIDTH-1:0] m);
      logic [63:0] r0, r1, s0, s1, quot, r_next, s_next, m_wide, folded, inv;
      inverse_result_type res;
      m_wide = {{(64 - WIDTH){1'b0}}, m};
      r0 = {{(64 - WIDTH){1'b0}}, a};
      r1 = m_wide;
      s0 = 64'd1;
      s1 = 64'd0;
      while (r1 != 64'd0) begin
         quot   = r0 / r1;
         r_next = r0 - quot * r1;
         s_next = s0 - quot * s1;
         r0 = r1;
         r1 = r_next;
         s0 = s1;
         s1 = s_next;
      end
      // A zero modulus skips the loop and reports inverse 0.
      if (m_wide == 64'd0) begin
         inv = 64'd0;
      end else if (s0[63]) begin
         folded = (64'd0 - s0) % m_wide;
         inv = (folded == 64'd0) ? m_wide : (m_wide - folded);
      end else begin
         folded = s0 % m_wide;
         inv = (folded == 64'd0) ? m_wide : folded;
      end
      res.inverse        = inv[WIDTH-1:0];
      res.common_divisor = r0[WIDTH-1:0];
      return res;
   endfunction

   // Check the strobed result before queueing a request taken at the same edge,
   // since the block may accept the next request while showing a result.
   always @(posedge clock) begin : check_results
      inverse_result_type want;
      if (reset) begin
         predicted_inverses.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_inverses.size() == 0) begin
               $error("unexpected result: inverse %0d, common_divisor %0d",
                      rsp_inverse, rsp_common_divisor);
               mismatch_count++;
            end else begin
               want = predicted_inverses.pop_front();
               if (rsp_inverse !== want.inverse) begin
                  $error("inverse: expected %0d, actual %0d", want.inverse, rsp_inverse);
                  mismatch_count++;
               end
               if (rsp_common_divisor !== want.common_divisor) begin
                  $error("common_divisor: expected %0d, actual %0d",
                         want.common_divisor, rsp_common_divisor);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            predicted_inverses.insert(predicted_inverses.size(),
                                      euclid_inverse(req_value_a, req_modulus));
         end
      end
      pending_requests = predicted_inverses.size();
   end

endmodule

>>> test/modular_inverse_ext_euclid_tb.sv
// Testbench top for the modular inverse block: clock, reset, directed and
// random requests in bursts, and the final verdict.
// Depends on modinv_pkg, modular_inverse_ext_euclid and modinv_result_checker.
module modular_inverse_ext_euclid_tb;
   import modinv_pkg::*;

   localparam int WIDTH = MODINV_WIDTH;
   localparam int RANDOM_REQUESTS = 400;
   localparam longint RUN_LIMIT = 64'd40_000_000;
   localparam logic [WIDTH-1:0] ALL_ONES = '1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [WIDTH-1:0] req_value_a = '0;
   logic [WIDTH-1:0] req_modulus = '0;
   logic             rsp_valid;
   logic [WIDTH-1:0] rsp_inverse;
   logic [WIDTH-1:0] rsp_common_divisor;
   int               mismatch_count;
   int               pending_requests;
   int               burst_left = 0;

   always #5 clock = ~clock;

   modular_inverse_ext_euclid #(.WIDTH(WIDTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value_a        (req_value_a),
      .req_modulus        (req_modulus),
      .rsp_valid          (rsp_valid),
      .rsp_inverse        (rsp_inverse),
      .rsp_common_divisor (rsp_common_divisor)
   );

   modinv_result_checker #(.WIDTH(WIDTH)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value_a        (req_value_a),
      .req_modulus        (req_modulus),
      .rsp_valid          (rsp_valid),
      .rsp_inverse        (rsp_inverse),
      .rsp_common_divisor (rsp_common_divisor),
      .mismatch_count     (mismatch_count),
      .pending_requests   (pending_requests)
   );

   function automatic logic [WIDTH-1:0] random_word();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[WIDTH-1:0];
   endfunction

   // Consecutive Fibonacci numbers give the longest Euclid runs.
   function automatic logic [WIDTH-1:0] fibonacci(input int n);
      logic [63:0] f0, f1, f_next;
      f0 = 64'd0;
      f1 = 64'd1;
      for (int i = 1; i < n; i++) begin
         f_next = f0 + f1;
         f0 = f1;
         f1 = f_next;
      end
      return f1[WIDTH-1:0];
   endfunction

   // Drive one request at a falling edge and return at the falling edge after
   // it was taken. Bursts of back-to-back requests are split by idle gaps,
   // now and then long enough that the block goes idle first.
   task automatic send_request(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] m);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 1600)
                                           : $urandom_range(0, 20);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_value_a <= a;
      req_modulus <= m;
      start       <= 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Operand mixes: full range, short words, small moduli, values below the modulus,
   // multiples of the modulus, shared factors, Fibonacci pairs, values near the modulus and special moduli.
   task automatic random_operands(output logic [WIDTH-1:0] a, output logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] factor;
      int n;
      case ($urandom_range(0, 9))
         1: begin
            a = random_word() >> $urandom_range(0, WIDTH - 1);
            m = random_word() >> $urandom_range(0, WIDTH - 1);
         end
         2: begin
            a = random_word();
            m = WIDTH'($urandom_range(1, 1000));
         end
         3: begin
            m = random_word();
            a = (m == '0) ? '0 : random_word() % m;
         end
         4: begin
            m = WIDTH'($urandom_range(1, 1 << 16));
            a = m * WIDTH'($urandom_range(0, 1 << 14));
         end
         5: begin
            n = $urandom_range(1, 45);
            if ($urandom_range(0, 1) == 0) begin
               a = fibonacci(n);
               m = fibonacci(n + 1);
            end else begin
               a = fibonacci(n + 1);
               m = fibonacci(n);
            end
         end
         6: begin
            factor = WIDTH'($urandom_range(2, 1000));
            a = factor * (random_word() >> 10);
            m = factor * (random_word() >> 10);
         end
         7: begin
            m = random_word();
            case ($urandom_range(0, 5))
               0: a = '0;
               1: a = WIDTH'(1);
               2: a = ALL_ONES;
               3: a = m - WIDTH'(1);
               4: a = m;
               default: a = m + WIDTH'(1);
            endcase
         end
         8: begin
            a = random_word();
            case ($urandom_range(0, 3))
               0: m = '0;
               1: m = WIDTH'(1);
               2: m = ALL_ONES;
               default: m = WIDTH'(2);
            endcase
         end
         default: begin
            a = random_word();
            m = random_word();
         end
      endcase
   endtask

   // Stimulus and verdict.
   initial begin
      logic [WIDTH-1:0] a, m;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero modulus, zero value, modulus one and operand extremes.
      send_request('0, '0);
      send_request(ALL_ONES, '0);
      send_request('0, ALL_ONES);
      send_request('0, WIDTH'(7));
      send_request(WIDTH'(5), WIDTH'(1));
      send_request(ALL_ONES, WIDTH'(1));
      send_request(WIDTH'(1), WIDTH'(1));
      // Ordinary inverses in both operand orders.
      send_request(WIDTH'(3), WIDTH'(7));
      send_request(WIDTH'(7), WIDTH'(3));
      send_request(WIDTH'(1), ALL_ONES);
      send_request(ALL_ONES, ALL_ONES - WIDTH'(1));
      send_request(WIDTH'(123456789), WIDTH'(1000000007));
      // No inverse: shared factors and equal operands; then an inverse against all ones.
      send_request(WIDTH'(12), WIDTH'(18));
      send_request(WIDTH'(2), WIDTH'(4));
      send_request(WIDTH'(10), WIDTH'(10));
      send_request(ALL_ONES, ALL_ONES);
      send_request(ALL_ONES - WIDTH'(2), ALL_ONES);
      // Longest Euclid runs and a power of two against all ones.
      send_request(fibonacci(45), fibonacci(46));
      send_request(fibonacci(46), fibonacci(45));
      send_request({1'b1, {(WIDTH - 1){1'b0}}}, ALL_ONES);
      send_request(ALL_ONES, {1'b1, {(WIDTH - 1){1'b0}}});

      repeat (RANDOM_REQUESTS) begin
         random_operands(a, m);
         send_request(a, m);
      end
      start <= 1'b0;

      // Drain the outstanding results, then allow a short settling time.
      while (pending_requests != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a hung block.
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

endmodule
